>>> rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // most results a single input byte can cause ('u', three digits, one byte)
  localparam int MAX_RES = 5;

  localparam logic [1:0] END_NONE  = 2'd0;
  localparam logic [1:0] END_QUOTE = 2'd1;
  localparam logic [1:0] END_BUF   = 2'd2;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] end_kind;
  } res_t;

  // all results caused by one input byte, oldest in slot 0
  typedef struct packed {
    logic [2:0]               count;
    res_t [MAX_RES-1:0]       res;
  } desc_t;

endpackage

>>> rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Decoder: tracks escape state and turns each input byte into a burst
// descriptor of zero to five result items.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  output logic               desc_push,
  output jsu_pkg::desc_t     desc
);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [15:0] CP_LIM1   = 16'h0080;
  localparam logic [15:0] CP_LIM2   = 16'h0800;
  localparam logic [7:0]  UTF8_L2   = 8'hC0;
  localparam logic [7:0]  UTF8_L3   = 8'hE0;
  localparam logic [7:0]  UTF8_CONT = 8'h80;
  localparam logic [15:0] CONT_MASK = 16'h003F;

  mode_t       mode, mode_next;
  logic [11:0] hex_value, hex_next;
  logic [1:0]  digit_count, cnt_next;
  logic [7:0]  held [3];
  logic        hold_we;

  logic [4:0]  dig;          // {ok, value}
  logic [15:0] cp;
  logic [2:0]  n;
  logic        plain_go;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] e);
    logic [7:0] r;
    case (e)
      CH_N:    r = CH_LF;
      CH_T:    r = CH_TAB;
      CH_R:    r = CH_CR;
      CH_B:    r = CH_BS;
      CH_F:    r = CH_FF;
      default: r = e;
    endcase
    return r;
  endfunction

  assign dig = hex_digit(in_byte);
  assign cp  = {hex_value, dig[3:0]};

  always_comb begin
    desc      = '0;
    n         = 3'd0;
    mode_next = mode;
    hex_next  = hex_value;
    cnt_next  = digit_count;
    hold_we   = 1'b0;
    plain_go  = 1'b0;

    unique case (mode)
      MODE_ESC: begin
        if (in_byte == CH_NUL) begin
          desc.res[0] = '{CH_BSLASH, 1'b1, jsu_pkg::END_NONE};
          desc.res[1] = '{8'h00, 1'b0, jsu_pkg::END_BUF};
          n           = 3'd2;
          mode_next   = MODE_PLAIN;
          hex_next    = '0;
          cnt_next    = '0;
        end else if (in_byte == CH_U) begin
          mode_next = MODE_HEX;
          hex_next  = '0;
          cnt_next  = '0;
        end else begin
          desc.res[0] = '{esc_map(in_byte), 1'b1, jsu_pkg::END_NONE};
          n           = 3'd1;
          mode_next   = MODE_PLAIN;
        end
      end
      MODE_HEX: begin
        if (!dig[4]) begin
          // bad digit: replay 'u' and the held digits, then treat as plain
          desc.res[0] = '{CH_U, 1'b1, jsu_pkg::END_NONE};
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < digit_count) desc.res[i+1] = '{held[i], 1'b1, jsu_pkg::END_NONE};
          end
          n         = 3'd1 + {1'b0, digit_count};
          mode_next = MODE_PLAIN;
          hex_next  = '0;
          cnt_next  = '0;
          plain_go  = 1'b1;
        end else if (digit_count != 2'd3) begin
          hold_we  = 1'b1;
          hex_next = {hex_value[7:0], dig[3:0]};
          cnt_next = digit_count + 2'd1;
        end else begin
          if (cp < CP_LIM1) begin
            desc.res[0] = '{cp[7:0], 1'b1, jsu_pkg::END_NONE};
            n           = 3'd1;
          end else if (cp < CP_LIM2) begin
            desc.res[0] = '{UTF8_L2 | {3'b000, cp[10:6]}, 1'b1, jsu_pkg::END_NONE};
            desc.res[1] = '{UTF8_CONT | 8'(cp & CONT_MASK), 1'b1, jsu_pkg::END_NONE};
            n           = 3'd2;
          end else begin
            desc.res[0] = '{UTF8_L3 | {4'b0000, cp[15:12]}, 1'b1, jsu_pkg::END_NONE};
            desc.res[1] = '{UTF8_CONT | {2'b00, cp[11:6]}, 1'b1, jsu_pkg::END_NONE};
            desc.res[2] = '{UTF8_CONT | 8'(cp & CONT_MASK), 1'b1, jsu_pkg::END_NONE};
            n           = 3'd3;
          end
          mode_next = MODE_PLAIN;
          hex_next  = '0;
          cnt_next  = '0;
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
        plain_go  = 1'b1;
      end
    endcase

    if (plain_go) begin
      if (in_byte == CH_NUL) begin
        desc.res[n] = '{8'h00, 1'b0, jsu_pkg::END_BUF};
        n           = n + 3'd1;
        hex_next    = '0;
        cnt_next    = '0;
      end else if (in_byte == CH_QUOTE) begin
        desc.res[n] = '{8'h00, 1'b0, jsu_pkg::END_QUOTE};
        n           = n + 3'd1;
        hex_next    = '0;
        cnt_next    = '0;
      end else if (in_byte == CH_BSLASH) begin
        mode_next = MODE_ESC;
      end else begin
        desc.res[n] = '{in_byte, 1'b1, jsu_pkg::END_NONE};
        n           = n + 3'd1;
      end
    end

    desc.count = n;
  end

  assign desc_push = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      hex_value   <= '0;
      digit_count <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      hex_value   <= hex_next;
      digit_count <= cnt_next;
    end
  end

  // digit store for replay; no reset, only entries below digit_count are read
  always_ff @(posedge clk) begin
    if (accept && hold_we) held[digit_count] <= in_byte;
  end

endmodule

>>> rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short descriptor queue between the decoder and the output sequencer.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  jsu_pkg::desc_t     wr_data,
  output logic               q_full,
  input  logic               rd,
  output jsu_pkg::desc_t     rd_data,
  output logic               q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::desc_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr, do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd)      count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

>>> rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output sequencer: walks the head descriptor one result per cycle into the
// output register while that register is empty or being popped.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk,
  input  logic               rst,
  input  jsu_pkg::desc_t     head,
  input  logic               head_empty,
  output logic               head_pop,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic [1:0]         end_kind,
  output logic               run_last
);

  logic          out_valid;
  jsu_pkg::res_t out_res;
  logic          out_last;
  logic [2:0]    idx;
  logic          load, last;

  assign load     = !head_empty && (!out_valid || pop);
  assign last     = (idx == head.count - 3'd1);
  assign head_pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= head.res[idx];
      out_last <= last;
    end
  end

  assign empty      = !out_valid;
  assign out_byte   = out_res.data;
  assign byte_valid = out_res.valid;
  assign end_kind   = out_res.end_kind;
  assign run_last   = out_last;

endmodule

>>> rtl/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top
// Streaming JSON string body unescaper with UTF-8 output for \u escapes.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle unless full, gives one result per cycle
// while pop is high; a byte's first result passes the descriptor queue
// and the output register before it shows. Input bytes that expand (\u
// escapes to two or three UTF-8 bytes, a bad hex digit replaying up to
// five bytes, backslash before a zero byte) keep the output sequencer
// busy; the QDEPTH-entry queue absorbs these bursts, and full rises only
// once it is exhausted. Backslashes and held hex digits give no result.
module json_string_unescape_top #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] end_kind,
  output logic       run_last
);

  jsu_pkg::desc_t fr_desc, hd_desc;
  logic           fr_push, hd_empty, hd_pop, accept;

  assign accept = push && !full;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .desc_push (fr_push),
    .desc      (fr_desc)
  );

  jsu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fr_push),
    .wr_data (fr_desc),
    .q_full  (full),
    .rd      (hd_pop),
    .rd_data (hd_desc),
    .q_empty (hd_empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (hd_desc),
    .head_empty (hd_empty),
    .head_pop   (hd_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .end_kind   (end_kind),
    .run_last   (run_last)
  );

endmodule

>>> rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [1:0] end_kind,
  input logic       run_last
);

  // nothing waits straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // a waiting result is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before transaction");

  // a stalled result holds its payload
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(out_byte) && $stable(byte_valid) &&
                          $stable(end_kind) && $stable(run_last)))
    else $error("stalled result changed");

  // an end marker carries no byte and closes its byte's burst
  a_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_kind != jsu_pkg::END_NONE) |->
      (!byte_valid && run_last &&
       (end_kind == jsu_pkg::END_QUOTE || end_kind == jsu_pkg::END_BUF)))
    else $error("malformed end result");

  // a result either carries a byte or ends the string
  a_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_kind == jsu_pkg::END_NONE) |-> byte_valid)
    else $error("empty result without end marker");

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (.*);

>>> tb/json_string_unescape_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_checker
// Watches both queue ports of the unescaper, predicts the decoded results of
// every accepted raw byte and compares each popped result field by field.
// ----------------------------------------------------------------------------
module json_string_unescape_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       byte_valid,
  input  logic [1:0] end_kind,
  input  logic       run_last,
  output int         errors,
  output int         waiting
);

  typedef enum logic [2:0] {
    MODE_TEXT   = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX    = 3'd2
  } unesc_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] kind;
    logic       last;
  } decoded_t;

  localparam logic [7:0] NUL = 8'h00;

  unesc_mode_t mode;
  logic [11:0] hex_acc;
  logic [7:0]  digits [3];
  logic [1:0]  ndigits;

  decoded_t step_res[$];
  decoded_t decoded_q[$];
  decoded_t want;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] escape_char(input logic [7:0] c);
    case (c)
      "n": return 8'h0A;
      "t": return 8'h09;
      "r": return 8'h0D;
      "b": return 8'h08;
      "f": return 8'h0C;
      default: return c;
    endcase
  endfunction

  task automatic emit(input logic [7:0] d, input logic v, input logic [1:0] k);
    step_res.push_back('{data: d, valid: v, kind: k, last: 1'b0});
  endtask

  task automatic clear_mode();
    mode = MODE_TEXT;
    hex_acc = '0;
    ndigits = '0;
  endtask

  task automatic text_byte(input logic [7:0] c);
    if (c == NUL) begin
      emit(NUL, 1'b0, jsu_pkg::END_BUF);
      clear_mode();
    end else if (c == "\"") begin
      emit(NUL, 1'b0, jsu_pkg::END_QUOTE);
      clear_mode();
    end else if (c == "\\") begin
      mode = MODE_ESCAPE;
    end else begin
      emit(c, 1'b1, jsu_pkg::END_NONE);
    end
  endtask

  task automatic emit_utf8(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      emit(cp[7:0], 1'b1, jsu_pkg::END_NONE);
    end else if (cp < 16'h0800) begin
      emit(8'hC0 | {3'b000, cp[10:6]}, 1'b1, jsu_pkg::END_NONE);
      emit(8'h80 | {2'b00, cp[5:0]}, 1'b1, jsu_pkg::END_NONE);
    end else begin
      emit(8'hE0 | {4'h0, cp[15:12]}, 1'b1, jsu_pkg::END_NONE);
      emit(8'h80 | {2'b00, cp[11:6]}, 1'b1, jsu_pkg::END_NONE);
      emit(8'h80 | {2'b00, cp[5:0]}, 1'b1, jsu_pkg::END_NONE);
    end
  endtask

  // works out every result one raw byte causes and queues them
  task automatic unescape_byte(input logic [7:0] c);
    int nib;
    logic [15:0] cp;
    step_res.delete();
    case (mode)
      MODE_ESCAPE: begin
        if (c == NUL) begin
          emit("\\", 1'b1, jsu_pkg::END_NONE);
          emit(NUL, 1'b0, jsu_pkg::END_BUF);
          clear_mode();
        end else if (c == "u") begin
          mode = MODE_HEX;
          hex_acc = '0;
          ndigits = '0;
        end else begin
          emit(escape_char(c), 1'b1, jsu_pkg::END_NONE);
          mode = MODE_TEXT;
        end
      end
      MODE_HEX: begin
        nib = hex_nibble(c);
        if (nib < 0) begin
          // replay 'u' and the held digits, then treat the byte as plain text
          emit("u", 1'b1, jsu_pkg::END_NONE);
          for (int i = 0; i < ndigits; i++) emit(digits[i], 1'b1, jsu_pkg::END_NONE);
          clear_mode();
          text_byte(c);
        end else if (ndigits < 3) begin
          digits[ndigits] = c;
          hex_acc = {hex_acc[7:0], nib[3:0]};
          ndigits = ndigits + 2'd1;
        end else begin
          cp = {hex_acc, nib[3:0]};
          emit_utf8(cp);
          clear_mode();
        end
      end
      default: begin
        mode = MODE_TEXT;
        text_byte(c);
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i]) decoded_q.push_back(step_res[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_mode();
      decoded_q.delete();
    end else begin
      // pop before push: a byte taken at this edge cannot have a result out yet
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got byte %h valid %b end %0d last %b",
                   $time, out_byte, byte_valid, end_kind, run_last);
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("byte_valid", {7'd0, want.valid}, {7'd0, byte_valid});
          check_field("end_kind", {6'd0, want.kind}, {6'd0, end_kind});
          check_field("run_last", {7'd0, want.last}, {7'd0, run_last});
        end
      end
      if (push && !full) unescape_byte(in_byte);
    end
    waiting = decoded_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives raw JSON string bytes into the unescaper: a directed set of escapes,
// \u sequences and string ends, then random well-formed strings mixed with
// broken escapes and noise, under random idling on both queue ports. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  localparam int         LIMIT       = 200000;
  localparam int         HOLD_CYCLES = 60;
  localparam int         DRAIN_LIMIT = 5000;
  localparam int         SETTLE      = 12;
  localparam logic [7:0] NUL         = 8'h00;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full, empty, byte_valid, run_last;
  logic [7:0] out_byte;
  logic [1:0] end_kind;

  int errors, waiting;
  int cycles = 0;
  int send_pct = 0;
  int stall_pct = 0;
  logic hold_off = 1'b0;

  json_string_unescape_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .empty(empty), .pop(pop), .out_byte(out_byte), .byte_valid(byte_valid),
    .end_kind(end_kind), .run_last(run_last)
  );

  json_string_unescape_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .empty(empty), .pop(pop), .out_byte(out_byte), .byte_valid(byte_valid),
    .end_kind(end_kind), .run_last(run_last), .errors(errors), .waiting(waiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b);
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  task automatic send_unicode(input logic [15:0] cp);
    send_byte("\\");
    send_byte("u");
    send_byte(hex_char(cp[15:12]));
    send_byte(hex_char(cp[11:8]));
    send_byte(hex_char(cp[7:4]));
    send_byte(hex_char(cp[3:0]));
  endtask

  // one piece of a string body: plain byte, escape, \u sequence, end or noise
  task automatic send_token();
    int pick, k;
    logic [7:0] b;
    logic [15:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 3) == 0) begin
        b = 8'($urandom_range(8'h80, 8'hFF));
      end else begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == "\"" || b == "\\") b = "a";
      end
      send_byte(b);
    end else if (pick < 55) begin
      send_byte("\\");
      case ($urandom_range(0, 8))
        0: b = "n";
        1: b = "t";
        2: b = "r";
        3: b = "b";
        4: b = "f";
        5: b = "/";
        6: b = "\"";
        7: b = "\\";
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end else if (pick < 70) begin
      case ($urandom_range(0, 7))
        0: cp = 16'h007F;
        1: cp = 16'h0080;
        2: cp = 16'h07FF;
        3: cp = 16'h0800;
        4, 5: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        6: cp = 16'($urandom_range(16'h0080, 16'h07FF));
        default: cp = 16'($urandom_range(16'h0000, 16'h007F));
      endcase
      send_unicode(cp);
    end else if (pick < 78) begin
      // broken \u: up to three digits then a byte that is not hex
      send_byte("\\");
      send_byte("u");
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) send_byte(hex_char(4'($urandom_range(0, 15))));
      case ($urandom_range(0, 5))
        0: b = "\"";
        1: b = NUL;
        2: b = "\\";
        3: b = "g";
        4: b = "u";
        default: b = 8'($urandom_range(8'h80, 8'hFF));
      endcase
      send_byte(b);
    end else if (pick < 86) begin
      send_byte(($urandom_range(0, 3) == 0) ? NUL : "\"");
    end else if (pick < 89) begin
      send_byte("\\");
      send_byte(NUL);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int n, input int s_pct, input int r_pct);
    send_pct = s_pct;
    stall_pct = r_pct;
    repeat (n) send_token();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, plain escapes, \u0000, three-byte form,
    // bad digit after three held, backslash before buffer end, quote
    send_pct = 20;
    stall_pct = 20;
    send_byte(8'hFF);
    send_byte("\\");
    send_byte("n");
    send_byte("\\");
    send_byte("q");
    send_unicode(16'h0000);
    send_byte("\\");
    send_byte("u");
    send_byte("F");
    send_byte("f");
    send_byte("F");
    send_byte("f");
    send_byte("\\");
    send_byte("u");
    send_byte("1");
    send_byte("2");
    send_byte("3");
    send_byte("\\");
    send_byte(NUL);
    send_byte("\"");
    wait_drained();

    // roughly two bytes per token on average
    run_phase(24, 25, 25);
    run_phase(24, 0, 0);

    // fill the block while the result side holds off, then let it drain
    hold_off = 1'b1;
    send_pct = 0;
    for (int i = 0; i < 24; i++) send_byte(8'("a" + i % 26));
    wait_drained();

    run_phase(24, 10, 40);
    run_phase(24, 50, 50);
    run_phase(24, 0, 0);
    push <= 1'b0;

    for (int k = 0; k < DRAIN_LIMIT && waiting != 0; k++) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (waiting != 0) $display("%0t: %0d expected results never arrived", $time, waiting);

    if (errors == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_top.sv
rtl/jsu_checker.sv
tb/json_string_unescape_checker.sv
tb/tb.sv
